@@ rtl/core/bsc_pkg.sv @@
// bsc_pkg: shared types, request codes and geometry constants for the bitmap scan/count core
// no dependencies; imported by every module of the core
`default_nettype none

package bsc_pkg;

    // field widths
    localparam int TYPE_W    = 3;
    localparam int BIDX_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int START_W   = 10;
    localparam int VALUE_W   = 11;

    // memory word geometry
    localparam int WORD_BITS = 64;
    localparam int WORD_LG   = 6;
    localparam int LANES     = WORD_BITS / BYTE_W;
    localparam int LANE_W    = 3;
    localparam int WNUM_W    = VALUE_W - WORD_LG;
    localparam int WLEFT_W   = WNUM_W + 1;

    localparam int MAX_BITS_DEFAULT = 1024;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_WRITE       = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_COUNT       = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_FIRST_SET   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_FIRST_CLEAR = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_LAST_SET    = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_LAST_CLEAR  = 3'd5;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [BIDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  byte_value;
        logic [START_W-1:0] start_bit;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               found;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    // per-word evaluation control
    typedef struct packed {
        logic               invert;
        logic               lo_cut;
        logic [WORD_LG-1:0] lo_off;
        logic               hi_cut;
        logic [WORD_LG-1:0] hi_off;
    } eval_ctrl_t;

    typedef struct packed {
        logic               any;
        logic [WORD_LG-1:0] low_idx;
        logic [WORD_LG-1:0] high_idx;
        logic [WORD_LG:0]   ones;
    } eval_res_t;

endpackage

`default_nettype wire

@@ rtl/core/bitmap_scan_and_count_core.sv @@
// bitmap_scan_and_count_core: top level, request sequencer around the bitmap memory
// depends on bsc_pkg, bsc_store, bsc_word_eval
`default_nettype none

// The bitmap lives in a 64-bit-wide memory; bit k is bit k%64 of word k/64.
// After reset the core sweeps the memory to zero, one word per cycle; busy
// stays high during the sweep. A request is taken when start is high and
// busy is low. Byte writes, unused codes and counts or searches with nothing
// to scan finish at once: the result shows with done in the next cycle and
// busy never rises. Other counts and searches read one word per cycle
// through the single read port; a search stops at the first word holding a
// hit. Results appear for exactly one cycle with done high; the receiver
// cannot stall, so the result must be captured in that cycle. bit_count may
// be written at any time through the cfg channel (always ready) but must
// only change while no request is in flight.

module bitmap_scan_and_count_core #(
    parameter int MAX_BITS = bsc_pkg::MAX_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire bsc_pkg::req_t                 req,
    output logic                               done,
    output bsc_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsc_pkg::VALUE_W-1:0]   cfg_data
);
    import bsc_pkg::*;

    localparam int WORDS       = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int STORE_BYTES = MAX_BITS / BYTE_W;

    // state and registers
    state_t state_reg, state_next;

    logic [VALUE_W-1:0] bit_count_reg;
    logic [WADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [TYPE_W-1:0]  op_reg, op_next;
    logic [WNUM_W-1:0]  lo_word_reg, lo_word_next;
    logic [WNUM_W-1:0]  hi_word_reg, hi_word_next;
    logic [WORD_LG-1:0] lo_off_reg, lo_off_next;
    logic [WORD_LG-1:0] hi_off_reg, hi_off_next;
    logic [WNUM_W-1:0]  issue_word_reg, issue_word_next;
    logic [WLEFT_W-1:0] issue_left_reg, issue_left_next;
    logic               eval_valid_reg, eval_valid_next;
    logic [WNUM_W-1:0]  eval_word_reg, eval_word_next;
    logic               eval_last_reg, eval_last_next;
    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    // memory interface
    logic                 wr_en;
    logic                 wr_clear;
    logic [WADDR_W-1:0]   wr_addr;
    logic                 rd_en;
    logic [WORD_BITS-1:0] rd_data;

    eval_ctrl_t ectrl;
    eval_res_t  eres;

    // decode helpers
    logic               accept;
    logic [VALUE_W-1:0] vlen;
    logic [VALUE_W-1:0] start_x;
    logic               req_down;
    logic               fwd_empty;
    logic [VALUE_W-1:0] lo_pos;
    logic [VALUE_W-1:0] hi_pos;
    logic               wr_in_range;

    logic               op_down;
    logic               op_search;
    logic               hit;
    logic               finish;
    logic               issuing;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // valid length: bit_count saturated to capacity
    assign vlen    = (32'(bit_count_reg) > MAX_BITS) ? VALUE_W'(MAX_BITS) : bit_count_reg;
    assign start_x = VALUE_W'(req.start_bit);

    assign req_down    = (req.req_type == REQ_LAST_SET) || (req.req_type == REQ_LAST_CLEAR);
    assign fwd_empty   = (vlen == '0) || (start_x >= vlen);
    assign wr_in_range = (32'(req.byte_index) < STORE_BYTES);

    // scan window in bit positions; backward start clamps to the last valid bit
    always_comb
    begin
        if (req_down)
        begin
            lo_pos = '0;
            hi_pos = (start_x >= vlen) ? (vlen - VALUE_W'(1)) : start_x;
        end
        else
        begin
            lo_pos = start_x;
            hi_pos = vlen - VALUE_W'(1);
        end
    end

    // scan status
    assign op_down   = (op_reg == REQ_LAST_SET) || (op_reg == REQ_LAST_CLEAR);
    assign op_search = (op_reg != REQ_COUNT);
    assign hit       = eval_valid_reg && op_search && eres.any;
    assign finish    = eval_valid_reg && (hit || eval_last_reg);
    assign issuing   = (state_reg == ST_SCAN) && (issue_left_reg != '0) && !finish;

    assign ectrl.invert = (op_reg == REQ_FIRST_CLEAR) || (op_reg == REQ_LAST_CLEAR);
    assign ectrl.lo_cut = (eval_word_reg == lo_word_reg);
    assign ectrl.lo_off = lo_off_reg;
    assign ectrl.hi_cut = (eval_word_reg == hi_word_reg);
    assign ectrl.hi_off = hi_off_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == WADDR_W'(WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_COUNT, REQ_FIRST_SET, REQ_FIRST_CLEAR:
                        begin
                            if (!fwd_empty)
                                state_next = ST_SCAN;
                        end
                        REQ_LAST_SET, REQ_LAST_CLEAR:
                        begin
                            if (vlen != '0)
                                state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine: handshake and memory controls
    always_comb
    begin
        busy     = 1'b1;
        wr_en    = 1'b0;
        wr_clear = 1'b0;
        wr_addr  = clr_addr_reg;
        rd_en    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy    = 1'b0;
                wr_addr = WADDR_W'(req.byte_index >> LANE_W);
                if (accept && (req.req_type == REQ_WRITE) && wr_in_range)
                    wr_en = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en = issuing;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        op_next         = op_reg;
        lo_word_next    = lo_word_reg;
        hi_word_next    = hi_word_reg;
        lo_off_next     = lo_off_reg;
        hi_off_next     = hi_off_reg;
        issue_word_next = issue_word_reg;
        issue_left_next = issue_left_reg;
        eval_valid_next = 1'b0;
        eval_word_next  = eval_word_reg;
        eval_last_next  = 1'b0;
        accum_next      = accum_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + WADDR_W'(1);
            end
            ST_IDLE:
            begin
                // load the scan window in every idle cycle; it is kept when a transaction is taken
                op_next         = req.req_type;
                lo_word_next    = lo_pos[VALUE_W-1:WORD_LG];
                hi_word_next    = hi_pos[VALUE_W-1:WORD_LG];
                lo_off_next     = lo_pos[WORD_LG-1:0];
                hi_off_next     = hi_pos[WORD_LG-1:0];
                issue_word_next = req_down ? hi_pos[VALUE_W-1:WORD_LG]
                                           : lo_pos[VALUE_W-1:WORD_LG];
                issue_left_next = WLEFT_W'(hi_pos[VALUE_W-1:WORD_LG])
                                - WLEFT_W'(lo_pos[VALUE_W-1:WORD_LG]) + WLEFT_W'(1);
                accum_next      = '0;
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_COUNT:
                        begin
                            if (fwd_empty)
                            begin
                                done_next   = 1'b1;
                                result_next = '{value: '0, found: 1'b1};
                            end
                        end
                        REQ_FIRST_SET, REQ_FIRST_CLEAR:
                        begin
                            if (fwd_empty)
                            begin
                                done_next   = 1'b1;
                                result_next = '{value: vlen, found: 1'b0};
                            end
                        end
                        REQ_LAST_SET, REQ_LAST_CLEAR:
                        begin
                            if (vlen == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '{value: vlen, found: 1'b0};
                            end
                        end
                        default:
                        begin
                            // byte write and unused codes
                            done_next   = 1'b1;
                            result_next = '{value: '0, found: 1'b0};
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // read issue side: one word per cycle
                if (issuing)
                begin
                    issue_word_next = op_down ? (issue_word_reg - WNUM_W'(1))
                                              : (issue_word_reg + WNUM_W'(1));
                    issue_left_next = issue_left_reg - WLEFT_W'(1);
                    eval_valid_next = 1'b1;
                    eval_word_next  = issue_word_reg;
                    eval_last_next  = (issue_left_reg == WLEFT_W'(1));
                end
                // evaluate side: word read last cycle
                if (eval_valid_reg)
                    accum_next = accum_reg + VALUE_W'(eres.ones);
                if (finish)
                begin
                    done_next = 1'b1;
                    if (hit)
                        result_next = '{value: {eval_word_reg,
                                                op_down ? eres.high_idx : eres.low_idx},
                                        found: 1'b1};
                    else if (!op_search)
                        result_next = '{value: accum_reg + VALUE_W'(eres.ones),
                                        found: 1'b1};
                    else
                        result_next = '{value: vlen, found: 1'b0};
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            bit_count_reg  <= '0;
            eval_valid_reg <= 1'b0;
            eval_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            eval_valid_reg <= eval_valid_next;
            eval_last_reg  <= eval_last_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
                bit_count_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        lo_word_reg    <= lo_word_next;
        hi_word_reg    <= hi_word_next;
        lo_off_reg     <= lo_off_next;
        hi_off_reg     <= hi_off_next;
        issue_word_reg <= issue_word_next;
        issue_left_reg <= issue_left_next;
        eval_word_reg  <= eval_word_next;
        accum_reg      <= accum_next;
        result_reg     <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    bsc_store #(
        .WORDS   (WORDS),
        .WADDR_W (WADDR_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_clear (wr_clear),
        .wr_addr  (wr_addr),
        .wr_lane  (req.byte_index[LANE_W-1:0]),
        .wr_byte  (req.byte_value),
        .rd_en    (rd_en),
        .rd_addr  (WADDR_W'(issue_word_reg)),
        .rd_data  (rd_data)
    );

    bsc_word_eval u_eval (
        .data (rd_data),
        .ctrl (ectrl),
        .res  (eres)
    );

endmodule

`default_nettype wire

@@ rtl/core/bsc_store.sv @@
// bsc_store: word-wide bitmap memory, byte-lane writes and whole-word clears, registered read
// depends on bsc_pkg
`default_nettype none

module bsc_store #(
    parameter int WORDS   = 16,
    parameter int WADDR_W = 4
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic                           wr_clear,
    input  wire logic [WADDR_W-1:0]             wr_addr,
    input  wire logic [bsc_pkg::LANE_W-1:0]     wr_lane,
    input  wire logic [bsc_pkg::BYTE_W-1:0]     wr_byte,
    input  wire logic                           rd_en,
    input  wire logic [WADDR_W-1:0]             rd_addr,
    output logic      [bsc_pkg::WORD_BITS-1:0]  rd_data
);
    import bsc_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_clear)
                mem[wr_addr] <= '0;
            else
                mem[wr_addr][wr_lane*BYTE_W +: BYTE_W] <= wr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/bsc_word_eval.sv @@
// bsc_word_eval: optionally inverts and masks one memory word, counts its ones, finds lowest and highest set bit
// depends on bsc_pkg
`default_nettype none

module bsc_word_eval (
    input  wire logic [bsc_pkg::WORD_BITS-1:0] data,
    input  wire bsc_pkg::eval_ctrl_t           ctrl,
    output bsc_pkg::eval_res_t                 res
);
    import bsc_pkg::*;

    logic [WORD_BITS-1:0] ones_w;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] bits;

    logic [LANES-1:0]       lane_any;
    logic [LANE_W-1:0]      lane_lo  [LANES];
    logic [LANE_W-1:0]      lane_hi  [LANES];
    logic [LANE_W:0]        lane_pop [LANES];

    assign ones_w  = '1;
    assign lo_mask = ctrl.lo_cut ? (ones_w << ctrl.lo_off) : ones_w;
    assign hi_mask = ctrl.hi_cut ? (ones_w >> (~ctrl.hi_off)) : ones_w;
    assign bits    = (ctrl.invert ? ~data : data) & lo_mask & hi_mask;

    // first level: per byte lane
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_any[k] = |bits[k*BYTE_W +: BYTE_W];
            lane_lo[k]  = '0;
            lane_hi[k]  = '0;
            lane_pop[k] = '0;
            for (int b = BYTE_W - 1; b >= 0; b--)
            begin
                if (bits[k*BYTE_W + b])
                    lane_lo[k] = LANE_W'(b);
            end
            for (int b = 0; b < BYTE_W; b++)
            begin
                if (bits[k*BYTE_W + b])
                    lane_hi[k] = LANE_W'(b);
                lane_pop[k] = lane_pop[k] + (LANE_W+1)'(bits[k*BYTE_W + b]);
            end
        end
    end

    // second level: across lanes
    always_comb
    begin
        res.any      = |lane_any;
        res.low_idx  = '0;
        res.high_idx = '0;
        res.ones     = '0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            if (lane_any[k])
                res.low_idx = {LANE_W'(k), lane_lo[k]};
        end
        for (int k = 0; k < LANES; k++)
        begin
            if (lane_any[k])
                res.high_idx = {LANE_W'(k), lane_hi[k]};
            res.ones = res.ones + (WORD_LG+1)'(lane_pop[k]);
        end
    end

endmodule

`default_nettype wire

@@ dv/bitmap_scan_and_count_checker.sv @@
`timescale 1ns / 100ps
// bitmap_scan_and_count_checker: watches the request, result and cfg channels of the core,
// predicts every result from a shadow copy of the bitmap and bit_count, and counts mismatches
// depends on bsc_pkg
module bitmap_scan_and_count_checker
    import bsc_pkg::*;
#(
    parameter int MAP_BITS = MAX_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  req_t                 req,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [VALUE_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    localparam int MAP_BYTES = MAP_BITS / 8;

    logic [BYTE_W-1:0]  shadow_bytes [MAP_BYTES];
    logic [VALUE_W-1:0] shadow_len;
    result_t            answer_q [$];
    result_t            oldest;

    initial
    begin
        fail_count = 0;
    end

    function automatic logic map_bit(int pos);
        return shadow_bytes[pos >> 3][pos & 7];
    endfunction

    // one request against the shadow state; byte writes update the shadow
    function automatic result_t scan_and_count(req_t r);
        int      n;
        int      s;
        int      p;
        logic    want;
        result_t res;
        n = (shadow_len > MAP_BITS) ? MAP_BITS : int'(shadow_len);
        res = '0;
        want = (r.req_type == REQ_FIRST_SET) || (r.req_type == REQ_LAST_SET);
        case (r.req_type)
            REQ_WRITE:
            begin
                if (r.byte_index < MAP_BYTES)
                    shadow_bytes[r.byte_index] = r.byte_value;
            end
            REQ_COUNT:
            begin
                for (p = int'(r.start_bit); p < n; p++)
                    res.value = res.value + VALUE_W'(map_bit(p));
                res.found = 1'b1;
            end
            REQ_FIRST_SET, REQ_FIRST_CLEAR:
            begin
                res.value = VALUE_W'(n);
                for (p = int'(r.start_bit); p < n; p++)
                begin
                    if (map_bit(p) == want)
                    begin
                        res.value = VALUE_W'(p);
                        res.found = 1'b1;
                        break;
                    end
                end
            end
            REQ_LAST_SET, REQ_LAST_CLEAR:
            begin
                res.value = VALUE_W'(n);
                if (n > 0)
                begin
                    // a start past the end is clamped to the last valid bit
                    s = (r.start_bit >= n) ? n - 1 : int'(r.start_bit);
                    for (p = s; p >= 0; p--)
                    begin
                        if (map_bit(p) == want)
                        begin
                            res.value = VALUE_W'(p);
                            res.found = 1'b1;
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_bytes[i])
                shadow_bytes[i] = '0;
            shadow_len = '0;
            answer_q.delete();
        end
        else
        begin
            // results first: a result always belongs to an earlier transaction
            if (done)
            begin
                if (answer_q.size() == 0)
                    report_mismatch($sformatf("result value=%0d found=%0b with nothing outstanding",
                                              result.value, result.found));
                else
                begin
                    oldest = answer_q.pop_front();
                    if (result.value !== oldest.value)
                        report_mismatch($sformatf("value got %0d expected %0d",
                                                  result.value, oldest.value));
                    if (result.found !== oldest.found)
                        report_mismatch($sformatf("found got %0b expected %0b",
                                                  result.found, oldest.found));
                end
            end
            if (start && !busy)
                answer_q.push_back(scan_and_count(req));
            if (cfg_valid && cfg_ready)
                shadow_len = cfg_data;
        end
        outstanding = answer_q.size();
    end

endmodule

@@ dv/bitmap_scan_and_count_core_tb.sv @@
`timescale 1ns / 100ps
// bitmap_scan_and_count_core_tb: stimulus and verdict for the bitmap scan/count core
// depends on bsc_pkg, bitmap_scan_and_count_core and bitmap_scan_and_count_checker
module bitmap_scan_and_count_core_tb;

    import bsc_pkg::*;

    localparam int MAP_BITS        = MAX_BITS_DEFAULT;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 92;

    // request codes the core leaves unused
    localparam logic [TYPE_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_B = 3'd7;

    // bit_count per random phase; zero marks a phase that draws its own length
    // (the empty-vector phase is covered by the directed part)
    logic [VALUE_W-1:0] len_plan [PHASES] = '{11'd1024, 11'd2047, 11'd37, 11'd64,
                                              11'd1023, 11'd1, 11'd8, 11'd513,
                                              11'd0, 11'd0, 11'd9, 11'd1025};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    req_t               req;
    logic               done;
    result_t            result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [VALUE_W-1:0] cfg_data;
    int                 fail_count;
    int                 outstanding;

    // valid length as the stimulus sees it, only used to aim start_bit and byte_index
    int                 valid_bits;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bitmap_scan_and_count_core #(
        .MAX_BITS (MAP_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bitmap_scan_and_count_checker #(
        .MAP_BITS (MAP_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic req_t make_req(logic [TYPE_W-1:0] kind, int idx, int val, int sb);
        req_t r;
        r.req_type   = kind;
        r.byte_index = BIDX_W'(idx);
        r.byte_value = BYTE_W'(val);
        r.start_bit  = START_W'(sb);
        return r;
    endfunction

    // random request; fill_bias 1 leans the map toward ones, 2 toward zeros
    function automatic req_t random_request(int fill_bias);
        req_t r;
        int   roll;
        r.byte_index = BIDX_W'($urandom_range(0, 127));
        r.byte_value = BYTE_W'($urandom_range(0, 255));
        r.start_bit  = START_W'($urandom_range(0, 1023));

        roll = $urandom_range(0, 99);
        if (roll < 40)
            r.req_type = REQ_WRITE;
        else if (roll < 44)
            r.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        else
            r.req_type = TYPE_W'($urandom_range(REQ_COUNT, REQ_LAST_CLEAR));

        // long runs of equal bytes make searches cross many words
        roll = $urandom_range(0, 9);
        if (fill_bias == 1 && roll < 5)
            r.byte_value = 8'hFF;
        else if (fill_bias == 2 && roll < 5)
            r.byte_value = 8'h00;
        else if (roll == 9)
            r.byte_value = 8'h01 << $urandom_range(0, 7);

        // keep most writes inside the valid part of the map
        if (valid_bits >= 8 && $urandom_range(0, 2) != 0)
            r.byte_index = BIDX_W'($urandom_range(0, (valid_bits - 1) / 8));

        // aim the start at the ends of the vector now and then
        case ($urandom_range(0, 7))
            0: r.start_bit = '0;
            1: r.start_bit = '1;
            2: r.start_bit = START_W'((valid_bits > 0) ? valid_bits - 1 : 0);
            3: r.start_bit = START_W'((valid_bits > 1023) ? 1023 : valid_bits);
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // hold start until the core takes the transaction, then return at the falling edge
    task automatic issue(req_t r);
        start = 1'b1;
        req   = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result, plus a little slack
    task automatic drain();
        start = 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0 || busy);
        repeat (4) @(negedge clk);
    endtask

    // bit_count write, only issued while the core is idle
    task automatic set_bit_count(logic [VALUE_W-1:0] len);
        cfg_valid = 1'b1;
        cfg_data  = len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid  = 1'b0;
        cfg_data   = VALUE_W'($urandom_range(0, 2047));
        valid_bits = (len > MAP_BITS) ? MAP_BITS : int'(len);
    endtask

    // run limit, well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int                 phase;
        int                 item;
        int                 idle_pct;
        logic [VALUE_W-1:0] len;

        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        valid_bits = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // empty vector straight after reset: bit_count is zero
        issue(make_req(REQ_COUNT, 0, 0, 0));
        issue(make_req(REQ_FIRST_SET, 0, 0, 0));
        issue(make_req(REQ_LAST_CLEAR, 0, 0, 1023));
        drain();

        // full length: marker bits at both ends and a full byte in the middle
        set_bit_count(11'd1024);
        issue(make_req(REQ_WRITE, 0, 8'h01, 0));
        issue(make_req(REQ_WRITE, 127, 8'h80, 1023));
        issue(make_req(REQ_WRITE, 64, 8'hFF, 0));
        issue(make_req(REQ_COUNT, 0, 0, 0));
        issue(make_req(REQ_COUNT, 0, 0, 1023));
        issue(make_req(REQ_FIRST_SET, 0, 0, 1));
        issue(make_req(REQ_FIRST_CLEAR, 0, 0, 0));
        issue(make_req(REQ_LAST_SET, 0, 0, 1023));
        issue(make_req(REQ_LAST_CLEAR, 0, 0, 1023));
        issue(make_req(REQ_LAST_SET, 0, 0, 511));
        issue(make_req(REQ_FIRST_SET, 0, 0, 1023));
        issue(make_req(REQ_SPARE_A, 127, 8'hFF, 1023));
        issue(make_req(REQ_SPARE_B, 0, 8'h00, 0));
        drain();

        // length above capacity saturates to the full map
        set_bit_count(11'd2047);
        issue(make_req(REQ_FIRST_CLEAR, 0, 0, 1023));
        issue(make_req(REQ_LAST_SET, 0, 0, 1023));
        drain();

        // short vector: counts and searches past the end, clamped backward start,
        // stale bits above the length are ignored
        set_bit_count(11'd100);
        issue(make_req(REQ_COUNT, 0, 0, 500));
        issue(make_req(REQ_FIRST_SET, 0, 0, 500));
        issue(make_req(REQ_LAST_SET, 0, 0, 1023));
        issue(make_req(REQ_FIRST_SET, 0, 0, 1));
        issue(make_req(REQ_WRITE, 127, 8'h00, 0));
        issue(make_req(REQ_LAST_CLEAR, 0, 0, 1023));

        // random phases: light sender gaps, then heavy gaps, then back to back
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            len = len_plan[phase];
            if (len == '0)
                len = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(1025, 2047))
                                                   : VALUE_W'($urandom_range(0, 1024));
            set_bit_count(len);
            idle_pct = (phase < 4) ? 6 : (phase < 8) ? 78 : 0;

            for (item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                // halfway through, let the core run completely dry
                if (item == ITEMS_PER_PHASE / 2)
                    drain();
                issue(random_request(phase % 3));
                if ($urandom_range(0, 99) < idle_pct)
                begin
                    start = 1'b0;
                    req   = random_request(0);
                    repeat ($urandom_range(1, 20)) @(negedge clk);
                end
            end
        end

        // all stimulus in: wait for the last results and a scan's worth of quiet
        drain();
        repeat (24) @(negedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
